[rtl/tlv_stream_parser_defines.svh]
// Assertion macros used by the TLV stream parser top level.
`ifndef TLV_STREAM_PARSER_DEFINES_SVH
`define TLV_STREAM_PARSER_DEFINES_SVH

// Clocked assertion, held off while in reset.
`define TLVSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define TLVSP_ASSERT_IMP(label, ante, cons, msg) \
    `TLVSP_ASSERT(label, (ante) |-> (cons), msg)

`endif

[rtl/tlvsp_pkg.sv]
// Package: types, codes and constants of the TLV stream parser.
`timescale 1ns / 1ps
`default_nettype none
package tlvsp_pkg;

    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam logic        CFG_IDX_BIG_ENDIAN = 1'b0;
    localparam logic        BIG_ENDIAN_RESET   = 1'b1;

    localparam logic [15:0] RESERVED_TYPE = 16'hffff;
    localparam logic [1:0]  HEADER_BYTES  = 2'd3; // last header byte index (4 bytes)

    // parse phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_VALUE   = 2'd1;
    localparam logic [1:0] PH_STOPPED = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK           = 2'd0;
    localparam status_t ST_VALUE_SHORT  = 2'd1;
    localparam status_t ST_RESERVED     = 2'd2;
    localparam status_t ST_HEADER_SHORT = 2'd3;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [15:0] byte_offset;
        logic        end_of_record;
        status_t     parse_status;
        logic        buffer_done;
    } result_t;

endpackage
`default_nettype wire

[rtl/tlvsp_core.sv]
// Input register, parse state and per-byte result logic.
`timescale 1ns / 1ps
`default_nettype none
module tlvsp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_in_byte,
    input  wire logic             s_last_byte,
    input  wire logic             big_endian,
    input  wire logic             out_free,
    output logic                  res_load,
    output tlvsp_pkg::result_t    res
);
    import tlvsp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hcount_reg, hcount_next;
    logic [23:0] hhold_reg, hhold_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;

    logic [15:0] hdr_type, hdr_len, left_dec;
    logic        emit;

    assign advance       = in_valid_reg && out_free;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // header fields from the three held bytes and the incoming fourth
    always_comb begin
        if (big_endian) begin
            hdr_type = {hhold_reg[7:0], hhold_reg[15:8]};
            hdr_len  = {hhold_reg[23:16], in_byte_reg};
        end else begin
            hdr_type = {hhold_reg[15:8], hhold_reg[7:0]};
            hdr_len  = {in_byte_reg, hhold_reg[23:16]};
        end
    end

    assign left_dec = left_reg - 16'd1;

    always_comb begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        hhold_next  = hhold_reg;
        type_next   = type_reg;
        left_next   = left_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        emit        = 1'b0;
        res         = '0;
        res.buffer_done = in_last_reg;

        unique case (phase_reg)
            PH_HEADER: begin
                if (hcount_reg != HEADER_BYTES) begin
                    hhold_next  = hhold_reg | ({16'b0, in_byte_reg} << {hcount_reg, 3'b000});
                    hcount_next = hcount_reg + 2'd1;
                    if (in_last_reg) begin
                        emit             = 1'b1;
                        res.parse_status = ST_HEADER_SHORT;
                    end
                end else begin
                    type_next   = hdr_type;
                    length_next = hdr_len;
                    hcount_next = 2'd0;
                    hhold_next  = '0;
                    offset_next = '0;
                    res.record_type   = hdr_type;
                    res.record_length = hdr_len;
                    if (hdr_type == RESERVED_TYPE) begin
                        phase_next       = PH_STOPPED;
                        emit             = 1'b1;
                        res.parse_status = ST_RESERVED;
                    end else if (hdr_len == 16'd0) begin
                        emit              = 1'b1;
                        res.end_of_record = 1'b1;
                    end else begin
                        phase_next = PH_VALUE;
                        left_next  = hdr_len;
                        if (in_last_reg) begin
                            emit             = 1'b1;
                            res.parse_status = ST_VALUE_SHORT;
                        end
                    end
                end
            end
            PH_VALUE: begin
                left_next   = left_dec;
                offset_next = offset_reg + 16'd1;
                emit              = 1'b1;
                res.has_byte      = 1'b1;
                res.out_byte      = in_byte_reg;
                res.record_type   = type_reg;
                res.record_length = length_reg;
                res.byte_offset   = offset_reg;
                if (left_dec == 16'd0) begin
                    res.end_of_record = 1'b1;
                    phase_next        = PH_HEADER;
                end else if (in_last_reg) begin
                    res.parse_status = ST_VALUE_SHORT;
                end
            end
            default: begin
                // stopped, and the unused code
                if (in_last_reg) begin
                    emit              = 1'b1;
                    res.record_type   = RESERVED_TYPE;
                    res.record_length = length_reg;
                    res.parse_status  = ST_RESERVED;
                end
            end
        endcase

        // end of buffer: start afresh
        if (in_last_reg) begin
            phase_next  = PH_HEADER;
            hcount_next = '0;
            hhold_next  = '0;
            type_next   = '0;
            left_next   = '0;
            offset_next = '0;
            length_next = '0;
        end
    end

    assign res_load = advance && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            hhold_reg  <= '0;
            type_reg   <= '0;
            left_reg   <= '0;
            offset_reg <= '0;
            length_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            hhold_reg  <= hhold_next;
            type_reg   <= type_next;
            left_reg   <= left_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
        end
    end

endmodule
`default_nettype wire

[rtl/tlvsp_out.sv]
// Result register between the parse logic and the m_ channel.
`timescale 1ns / 1ps
`default_nettype none
module tlvsp_out (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                res_load,
    input  wire tlvsp_pkg::result_t  res,
    output logic                     out_free,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tlvsp_pkg::result_t       m_res
);
    import tlvsp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign out_free       = !out_valid_reg || m_ready;
    assign out_valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_load) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule
`default_nettype wire

[rtl/tlv_stream_parser.sv]
// Top level of the TLV stream parser: config register, core, result register.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_      | in  | s_valid/s_ready   | s_in_byte, s_last_byte
//  m_      | out | m_valid/m_ready   | has_byte, out_byte, type, length, offset,
//          |     |                   | end_of_record, parse_status, buffer_done
//  apb     | in  | psel/penable      | paddr, pwdata, prdata (big_endian at 0x0)
//
// One byte per cycle sustained while m_ does not stall; a request is held in
// the input register, and its result goes into the result register as the
// request leaves it, from where it is offered on m_.
// Parse state updates once per byte in the core: a counter, a decrement and
// a compare. The first three header bytes give no result unless they end the
// buffer. Synchronous active-low reset clears both valid flags and the parse
// state; big_endian returns to 1. A stall on m_ holds the input register and
// the parse state, so s_ready drops while a result waits on m_ and the input
// register holds a byte, whether or not that byte gives a result.
`timescale 1ns / 1ps
`default_nettype none
`include "tlv_stream_parser_defines.svh"
module tlv_stream_parser (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input bytes
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_in_byte,
    input  wire logic                           s_last_byte,
    // results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_has_byte,
    output logic [7:0]                          m_out_byte,
    output logic [15:0]                         m_record_type,
    output logic [15:0]                         m_record_length,
    output logic [15:0]                         m_byte_offset,
    output logic                                m_end_of_record,
    output logic [1:0]                          m_parse_status,
    output logic                                m_buffer_done,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tlvsp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tlvsp_pkg::PDATA_W-1:0]  pwdata,
    output logic [tlvsp_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import tlvsp_pkg::*;

    logic    big_endian_reg, big_endian_next;
    logic    cfg_hit;
    logic    out_free;
    logic    res_load;
    result_t res;
    result_t m_res;

    // ---- configuration register ----
    // Only register index 0 decodes; word offsets beyond it are ignored.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1] == CFG_IDX_BIG_ENDIAN);
    assign big_endian_next = (psel && penable && pwrite && cfg_hit) ? pwdata[0]
                                                                     : big_endian_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= BIG_ENDIAN_RESET;
        end else begin
            big_endian_reg <= big_endian_next;
        end
    end

    assign prdata = cfg_hit ? {{(PDATA_W-1){1'b0}}, big_endian_reg} : '0;

    // ---- parse core: input register plus per-byte state update ----
    tlvsp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .big_endian  (big_endian_reg),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    // ---- result register ----
    tlvsp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_has_byte      = m_res.has_byte;
    assign m_out_byte      = m_res.out_byte;
    assign m_record_type   = m_res.record_type;
    assign m_record_length = m_res.record_length;
    assign m_byte_offset   = m_res.byte_offset;
    assign m_end_of_record = m_res.end_of_record;
    assign m_parse_status  = m_res.parse_status;
    assign m_buffer_done   = m_res.buffer_done;

    // ---- assertions ----
    // a free result register must never hold back the input side
    `TLVSP_ASSERT_IMP(a_no_needless_stall, (!m_valid || m_ready), s_ready, "input stalled while output free")
    // value bytes only come with ok or value-short status
    `TLVSP_ASSERT_IMP(a_byte_status, (m_valid && m_has_byte), (m_parse_status == ST_OK || m_parse_status == ST_VALUE_SHORT), "value byte with stop status")
    // header cut short only ever ends a buffer
    `TLVSP_ASSERT_IMP(a_hdr_short_done, (m_valid && m_parse_status == ST_HEADER_SHORT), m_buffer_done, "header short without buffer end")
    // results without a byte carry zero byte and offset
    `TLVSP_ASSERT_IMP(a_empty_result, (m_valid && !m_has_byte), (m_out_byte == 8'd0 && m_byte_offset == 16'd0), "byte-less result carries data")

endmodule
`default_nettype wire

[dv/tlv_stream_parser_test.sv]
// Self-checking testbench for the TLV stream parser: directed rows, then random buffers.
`timescale 1ns / 1ps
module tlv_stream_parser_test;
    import tlvsp_pkg::*;

    // Cycles with no transfer on any port before the run is called hung.
    localparam int QUIET_LIMIT = 2000;
    // Random requests (ignored bytes after a reserved type excluded) per phase.
    localparam int PHASE_QUOTA = 240;
    localparam int NUM_PHASES  = 6;

    // Register map: word-spaced, the spare word has no register behind it.
    localparam logic [PADDR_W-1:0] BIG_ENDIAN_ADDR = PADDR_W'(4 * int'(CFG_IDX_BIG_ENDIAN));
    localparam logic [PADDR_W-1:0] SPARE_ADDR      =
        PADDR_W'(4 * (int'(CFG_IDX_BIG_ENDIAN) + 1));

    // Parser state as the scoreboard tracks it.
    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  hdr_count;
        logic [23:0] hdr_bytes;
        logic [15:0] rec_type;
        logic [15:0] rec_length;
        logic [15:0] remaining;
        logic [15:0] next_offset;
    } parse_state_t;

    // One row of the directed table; res is used only where typed is set.
    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        result_t    res;
    } stim_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [7:0]          s_in_byte   = 8'h00;
    logic                s_last_byte = 1'b0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic                m_has_byte;
    logic [7:0]          m_out_byte;
    logic [15:0]         m_record_type;
    logic [15:0]         m_record_length;
    logic [15:0]         m_byte_offset;
    logic                m_end_of_record;
    logic [1:0]          m_parse_status;
    logic                m_buffer_done;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    parse_state_t parser;
    logic         cfg_big_endian = BIG_ENDIAN_RESET;
    result_t      expected_results[$];
    logic [7:0]   buffer_bytes[$];
    int           mismatches    = 0;
    int           items_parsed  = 0;
    int           quiet_cycles  = 0;
    int           send_gap_pct  = 0;
    int           recv_stall_pct = 0;

    // Idling schedule and byte order per random phase; both orders visited three times over.
    int phase_big_endian[NUM_PHASES] = '{0, 1, 0, 1, 0, 1};
    int phase_send_gap[NUM_PHASES]   = '{0, 52, 0, 22, 52, 0};
    int phase_recv_stall[NUM_PHASES] = '{0, 0, 52, 22, 0, 52};

    // Directed part, run at the reset byte order (big-endian). Rows with a typed
    // result are the ones readable straight off the spec; the rest go through
    // the predictor.
    stim_row_t directed_rows[26] = '{
        // single-byte buffer: header cut short at once
        '{8'hA5, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                               1'b0, ST_HEADER_SHORT, 1'b1}},
        // type 0x0001 with an empty value: lone end-of-record result
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 16'h0001, 16'h0000, 16'h0000,
                               1'b1, ST_OK, 1'b0}},
        // type 0x1234, two value bytes at both byte extremes, buffer ends cleanly
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        // type 0xfffe, length 0xffff: value cut short on its first byte
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFE, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 16'hFFFE, 16'hFFFF, 16'h0000,
                               1'b0, ST_VALUE_SHORT, 1'b1}},
        // reserved type stops parsing; trailing bytes ignored up to the final one
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b1, '{1'b0, 8'h00, 16'hFFFF, 16'h0005, 16'h0000,
                               1'b0, ST_RESERVED, 1'b0}},
        '{8'h7E, 1'b0, 1'b0, '0},
        '{8'h81, 1'b1, 1'b1, '{1'b0, 8'h00, 16'hFFFF, 16'h0005, 16'h0000,
                               1'b0, ST_RESERVED, 1'b1}},
        // buffer ends on the fourth header byte with value still owed
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h03, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0007, 16'h0003, 16'h0000,
                               1'b0, ST_VALUE_SHORT, 1'b1}}
    };

    tlv_stream_parser uut (.*);

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scoreboard predictor: advances the tracked state by one byte and returns 1
    // if that byte produces a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output result_t res);
        logic [7:0]  h0, h1, h2;
        bit          got;
        got = 1'b0;
        res = '0;
        h0  = parser.hdr_bytes[7:0];
        h1  = parser.hdr_bytes[15:8];
        h2  = parser.hdr_bytes[23:16];
        case (parser.phase)
            PH_HEADER: begin
                if (parser.hdr_count != HEADER_BYTES) begin
                    parser.hdr_bytes[8*parser.hdr_count +: 8] = b;
                    parser.hdr_count = parser.hdr_count + 2'd1;
                    if (last) begin
                        res.parse_status = ST_HEADER_SHORT;
                        res.buffer_done  = 1'b1;
                        got = 1'b1;
                    end
                end else begin
                    // byte order sampled on the fourth header byte
                    if (cfg_big_endian) begin
                        parser.rec_type   = {h0, h1};
                        parser.rec_length = {h2, b};
                    end else begin
                        parser.rec_type   = {h1, h0};
                        parser.rec_length = {b, h2};
                    end
                    parser.hdr_count   = '0;
                    parser.hdr_bytes   = '0;
                    parser.next_offset = '0;
                    res.record_type   = parser.rec_type;
                    res.record_length = parser.rec_length;
                    res.buffer_done   = last;
                    if (parser.rec_type == RESERVED_TYPE) begin
                        parser.phase     = PH_STOPPED;
                        res.parse_status = ST_RESERVED;
                        got = 1'b1;
                    end else if (parser.rec_length == 16'h0000) begin
                        res.end_of_record = 1'b1;
                        got = 1'b1;
                    end else begin
                        parser.phase     = PH_VALUE;
                        parser.remaining = parser.rec_length;
                        if (last) begin
                            res.parse_status = ST_VALUE_SHORT;
                            got = 1'b1;
                        end
                    end
                end
            end
            PH_VALUE: begin
                res.has_byte      = 1'b1;
                res.out_byte      = b;
                res.record_type   = parser.rec_type;
                res.record_length = parser.rec_length;
                res.byte_offset   = parser.next_offset;
                res.buffer_done   = last;
                parser.remaining   = parser.remaining - 16'd1;
                parser.next_offset = parser.next_offset + 16'd1;
                if (parser.remaining == 16'h0000) begin
                    res.end_of_record = 1'b1;
                    parser.phase      = PH_HEADER;
                end else if (last) begin
                    res.parse_status = ST_VALUE_SHORT;
                end
                got = 1'b1;
            end
            default: begin
                // stopped (and the spare phase code): silent until the final byte
                if (last) begin
                    res.record_type   = RESERVED_TYPE;
                    res.record_length = parser.rec_length;
                    res.parse_status  = ST_RESERVED;
                    res.buffer_done   = 1'b1;
                    got = 1'b1;
                end
            end
        endcase
        // any final byte starts the next buffer from scratch
        if (last) begin
            parser       = '0;
            parser.phase = PH_HEADER;
        end
        return got;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // One APB transfer: setup, then access until pready; prdata taken at the access edge.
    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Set the byte order, poke the unmapped word (must be ignored), read back.
    task automatic set_byte_order(input logic be);
        logic [PDATA_W-1:0] rd;
        apb_xfer(1'b1, BIG_ENDIAN_ADDR, PDATA_W'(be), rd);
        cfg_big_endian = be;
        apb_xfer(1'b1, SPARE_ADDR, '1, rd);
        apb_xfer(1'b0, BIG_ENDIAN_ADDR, '0, rd);
        if (rd !== PDATA_W'(be)) begin
            $error("big_endian: expected %0h, got %0h", be, rd);
            mismatches++;
        end
    endtask

    // Present one request, hold it until taken, then log what it should produce.
    // A typed row overrides the predicted result, though the state still advances.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input result_t typed_res);
        result_t    predicted;
        bit         got;
        logic [1:0] phase_before;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        phase_before = parser.phase;
        got = parse_byte(b, last, predicted);
        if (phase_before != PH_STOPPED)
            items_parsed++;
        if (typed)
            expected_results.push_back(typed_res);
        else if (got)
            expected_results.push_back(predicted);
    endtask

    task automatic push_header(input logic [15:0] rtype, input logic [15:0] rlen,
                               input logic be);
        if (be) begin
            buffer_bytes.push_back(rtype[15:8]);
            buffer_bytes.push_back(rtype[7:0]);
            buffer_bytes.push_back(rlen[15:8]);
            buffer_bytes.push_back(rlen[7:0]);
        end else begin
            buffer_bytes.push_back(rtype[7:0]);
            buffer_bytes.push_back(rtype[15:8]);
            buffer_bytes.push_back(rlen[7:0]);
            buffer_bytes.push_back(rlen[15:8]);
        end
    endtask

    // Mostly well-formed buffers of a few records, some cut at a random byte;
    // the rest short noise or a huge declared length that the buffer cannot meet.
    task automatic build_buffer();
        int          kind, nrec, r, n;
        logic [15:0] rtype, rlen;
        logic        be;
        bit          stopped;
        buffer_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 80) begin
            nrec    = $urandom_range(1, 4);
            stopped = 1'b0;
            for (int i = 0; i < nrec && !stopped; i++) begin
                r = $urandom_range(99);
                if (r < 6)
                    rtype = RESERVED_TYPE;
                else if (r < 10)
                    rtype = 16'h0000;
                else if (r < 14)
                    rtype = 16'hFFFE;
                else
                    rtype = 16'($urandom);
                r = $urandom_range(99);
                if (r < 25)
                    rlen = 16'h0000;
                else if (r < 85)
                    rlen = 16'($urandom_range(1, 6));
                else
                    rlen = 16'($urandom_range(7, 40));
                // now and then the header goes in the wrong order
                be = ($urandom_range(19) == 0) ? !cfg_big_endian : cfg_big_endian;
                push_header(rtype, rlen, be);
                if (rtype == RESERVED_TYPE) begin
                    n = $urandom_range(0, 3);
                    repeat (n) buffer_bytes.push_back(8'($urandom));
                    stopped = 1'b1;
                end else begin
                    repeat (rlen) buffer_bytes.push_back(8'($urandom));
                end
            end
            // truncation lands in a header or a value alike
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, buffer_bytes.size());
                while (buffer_bytes.size() > n)
                    void'(buffer_bytes.pop_back());
            end
        end else if (kind < 92) begin
            n = $urandom_range(1, 8);
            repeat (n) buffer_bytes.push_back(8'($urandom));
        end else begin
            rtype = 16'($urandom_range(0, 16'hFFFE));
            rlen  = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(100, 16'hFFFE));
            push_header(rtype, rlen, cfg_big_endian);
            n = $urandom_range(0, 5);
            repeat (n) buffer_bytes.push_back(8'($urandom));
        end
    endtask

    // Result side: random back-pressure, every accepted result checked in order.
    always @(posedge aclk) begin : result_check
        result_t actual, want;
        if (aresetn && m_valid && m_ready) begin
            actual = {m_has_byte, m_out_byte, m_record_type, m_record_length,
                      m_byte_offset, m_end_of_record, m_parse_status, m_buffer_done};
            if (expected_results.size() == 0) begin
                $error("unexpected result: %0h", actual);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("has_byte", want.has_byte, actual.has_byte);
                check_field("out_byte", want.out_byte, actual.out_byte);
                check_field("record_type", want.record_type, actual.record_type);
                check_field("record_length", want.record_length, actual.record_length);
                check_field("byte_offset", want.byte_offset, actual.byte_offset);
                check_field("end_of_record", want.end_of_record, actual.end_of_record);
                check_field("parse_status", want.parse_status, actual.parse_status);
                check_field("buffer_done", want.buffer_done, actual.buffer_done);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any request, result or APB cycle counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        parser       = '0;
        parser.phase = PH_HEADER;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // drain, then wait out header bytes still in flight
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
            set_byte_order(phase_big_endian[p][0]);
            send_gap_pct   = phase_send_gap[p];
            recv_stall_pct = phase_recv_stall[p];
            items_parsed   = 0;
            while (items_parsed < PHASE_QUOTA) begin
                build_buffer();
                foreach (buffer_bytes[k])
                    send_byte(buffer_bytes[k], k == buffer_bytes.size() - 1, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
